// File: sv/disparity_to_point_reprojection_top_assert.svh
// Assertion macros shared by the reprojection block.
`ifndef DISPARITY_TO_POINT_REPROJECTION_TOP_ASSERT_SVH
`define DISPARITY_TO_POINT_REPROJECTION_TOP_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define DPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define DPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/dpr_pkg.sv
package dpr_pkg;
    localparam int unsigned MaxWidthDef  = 4096;
    localparam int unsigned MaxPointsDef = 1048576;
    localparam int unsigned DivBits      = 64;
    localparam int unsigned QueueDepth   = 2;

    typedef enum logic [7:0] {
        REG_FOCAL_X    = 8'd0,
        REG_FOCAL_Y    = 8'd1,
        REG_CENTER_X   = 8'd2,
        REG_CENTER_Y   = 8'd3,
        REG_DISP_SCALE = 8'd4,
        REG_DISP_OFFS  = 8'd5,
        REG_BASELINE   = 8'd6,
        REG_IMG_WIDTH  = 8'd7
    } t_reg_idx;

    // Classified pixel handed from front to back.
    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic        over;
        logic [7:0]  inten;
        logic [16:0] disp;
    } t_job;

    // Saturate sign/magnitude to 32-bit two's complement.
    function automatic logic [31:0] sat32(input logic [63:0] mag, input logic neg);
        logic [31:0] res;
        if (neg) begin
            if (mag >= 64'h8000_0000) res = 32'h8000_0000;
            else res = 32'd0 - mag[31:0];
        end else begin
            if (mag > 64'h7FFF_FFFF) res = 32'h7FFF_FFFF;
            else res = mag[31:0];
        end
        return res;
    endfunction
endpackage

// File: sv/dpr_front.sv
module dpr_front #(
    parameter int unsigned MAX_WIDTH  = dpr_pkg::MaxWidthDef,
    parameter int unsigned MAX_POINTS = dpr_pkg::MaxPointsDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [16:0]   i_disp,
    input  logic [7:0]    i_inten,
    input  logic          i_sof,
    input  logic [12:0]   i_image_width,
    output logic          o_push,
    output dpr_pkg::t_job o_job,
    input  logic          i_full
);
    import dpr_pkg::*;
    localparam int unsigned PcW = $clog2(MAX_POINTS + 1);

    logic [11:0]    r_col, r_row, n_col, n_row, col_now, row_now;
    logic [PcW-1:0] r_pc, n_pc, pc_now;
    logic [14:0]    width;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        width = {2'b0, i_image_width};
        if (i_image_width == 13'd0 || 32'(i_image_width) > MAX_WIDTH) width = 15'(MAX_WIDTH);
        col_now = i_sof ? 12'd0 : r_col;
        row_now = i_sof ? 12'd0 : r_row;
        pc_now  = i_sof ? '0 : r_pc;
        o_job.col   = col_now;
        o_job.row   = row_now;
        o_job.over  = 32'(pc_now) >= MAX_POINTS;
        o_job.inten = i_inten;
        o_job.disp  = i_disp;
        n_pc = (32'(pc_now) < MAX_POINTS) ? pc_now + 1'b1 : pc_now;
        if (15'(col_now) + 15'd1 >= width) begin
            n_col = 12'd0;
            n_row = row_now + 12'd1;
        end else begin
            n_col = col_now + 12'd1;
            n_row = row_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_pc <= '0;
        end else if (o_push) begin
            r_col <= n_col; r_row <= n_row; r_pc <= n_pc;
        end
    end
endmodule

// File: sv/dpr_queue.sv
module dpr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dpr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_avail,
    output dpr_pkg::t_job o_job
);
    import dpr_pkg::*;
    t_job r_mem [QueueDepth];
    logic [$clog2(QueueDepth):0] r_cnt;
    logic [$clog2(QueueDepth)-1:0] r_wp, r_rp;

    assign o_full  = r_cnt == QueueDepth[$clog2(QueueDepth):0];
    assign o_avail = r_cnt != '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= '0; r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

    `include "disparity_to_point_reprojection_top_assert.svh"
    `DPR_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, o_full, !i_push)
    `DPR_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, !o_avail, !i_pop)
    `DPR_ASSERT_NEXT(a_cnt_range, i_clk, i_rst_n, 1'b1,
        r_cnt <= QueueDepth[$clog2(QueueDepth):0])
endmodule

// File: sv/dpr_divider.sv
// Restoring divider, one quotient bit per cycle, 64-bit unsigned.
module dpr_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    import dpr_pkg::*;
    logic [63:0] r_q, r_rem, r_den;
    logic [64:0] trial;
    logic [6:0]  r_cnt;
    logic        r_busy;

    assign o_quot = r_q;
    assign trial  = {r_rem, r_q[63]} - {1'b0, r_den};
    assign o_done = r_busy && r_cnt == 7'(DivBits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1; r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (o_done) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num; r_rem <= '0; r_den <= i_den;
        end else if (r_busy && !o_done) begin
            if (!trial[64]) begin
                r_rem <= trial[63:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= {r_rem[62:0], r_q[63]};
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end
endmodule

// File: sv/dpr_back.sv
module dpr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_avail,
    input  dpr_pkg::t_job i_job,
    output logic          o_pop,
    input  logic [31:0]   i_focal_x,
    input  logic [31:0]   i_focal_y,
    input  logic [31:0]   i_center_x,
    input  logic [31:0]   i_center_y,
    input  logic [31:0]   i_disp_scale,
    input  logic [31:0]   i_disp_offset,
    input  logic [31:0]   i_baseline,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_px,
    output logic [31:0]   o_py,
    output logic [31:0]   o_pz,
    output logic [7:0]    o_inten,
    output logic          o_pvalid,
    output logic          o_over
);
    import dpr_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001, S_DEN  = 10'b0000000010, S_NUM  = 10'b0000000100,
        S_ZDIV = 10'b0000001000, S_XMUL = 10'b0000010000, S_XDIV = 10'b0000100000,
        S_YMUL = 10'b0001000000, S_YDIV = 10'b0010000000, S_OUT  = 10'b0100000000,
        S_DMUL = 10'b1000000000
    } t_state;

    t_state r_st;
    t_job   r_job;
    logic signed [49:0] r_dprod;
    logic signed [50:0] r_den;
    logic [63:0] r_num, den_mag;
    logic        r_neg;
    logic [31:0] r_z, r_x, r_y;
    logic        r_pv;
    logic        div_start, div_done;
    logic [63:0] div_num, div_den, div_q;
    logic signed [44:0] diff_x, diff_y, diff;
    logic [31:0] zabs, focal;
    logic [43:0] dabs;

    assign o_pop = r_st == S_IDLE && i_avail;

    assign diff_x = $signed({5'b0, r_job.col, 28'b0} >> 12) - $signed({13'b0, i_center_x});
    assign diff_y = $signed({5'b0, r_job.row, 28'b0} >> 12) - $signed({13'b0, i_center_y});
    assign diff   = (r_st == S_XMUL) ? diff_x : diff_y;
    assign focal  = (r_st == S_XMUL) ? i_focal_x : i_focal_y;
    assign zabs   = r_z[31] ? 32'd0 - r_z : r_z;
    assign dabs   = diff[44] ? 44'(-diff) : diff[43:0];
    assign den_mag = 64'(r_den[50] ? -r_den : r_den);

    always_comb begin
        div_start = 1'b0;
        div_num   = r_num;
        div_den   = den_mag;
        unique case (r_st)
            S_NUM:  begin div_start = 1'b1; end
            S_XMUL, S_YMUL: begin
                div_start = 1'b1;
                div_num   = 64'(dabs) * 64'(zabs);
                div_den   = {32'd0, focal};
            end
            default: ;
        endcase
    end

    dpr_divider u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num), .i_den(div_den),
        .o_done(div_done), .o_quot(div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_st != S_OUT) o_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_avail) begin r_job <= i_job; r_st <= S_DMUL; end
                S_DMUL: begin
                    r_dprod <= $signed(r_job.disp) * $signed(i_disp_scale);
                    r_st <= S_DEN;
                end
                S_DEN: begin
                    r_den <= 51'(r_dprod) + 51'($signed(i_disp_offset));
                    r_st  <= S_NUM;
                    r_num <= 64'(i_baseline) * 64'(i_focal_x);
                end
                S_NUM: begin
                    if (r_den == '0) begin
                        r_z <= '0; r_x <= '0; r_y <= '0; r_pv <= 1'b0;
                        r_st <= S_OUT;
                    end else begin
                        r_neg <= r_den[50];
                        r_st  <= S_ZDIV;
                    end
                end
                S_ZDIV: if (div_done) begin
                    r_z <= sat32(div_q, r_neg); r_st <= S_XMUL;
                end
                S_XMUL: r_st <= S_XDIV;
                S_XDIV: if (div_done) begin
                    r_x <= (i_focal_x == 0) ? 32'd0 : sat32(div_q, diff_x[44] != r_z[31]);
                    r_st <= S_YMUL;
                end
                S_YMUL: r_st <= S_YDIV;
                S_YDIV: if (div_done) begin
                    r_y <= (i_focal_y == 0) ? 32'd0 : sat32(div_q, diff_y[44] != r_z[31]);
                    r_pv <= 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: if (!o_valid || i_ready) begin
                    o_valid <= 1'b1; o_px <= r_x; o_py <= r_y; o_pz <= r_z;
                    o_pvalid <= r_pv; o_inten <= r_job.inten; o_over <= r_job.over;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `include "disparity_to_point_reprojection_top_assert.svh"
    `DPR_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_pop, r_st == S_IDLE)
    `DPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `DPR_ASSERT_IMPL(a_inval_zero, i_clk, i_rst_n, o_valid && !o_pvalid,
        o_pz == 32'd0 && o_px == 32'd0)
endmodule

// File: sv/disparity_to_point_reprojection_top.sv
// Stereo disparity to 3D point reprojection.
// Input stream s_axis: tdata = {start_of_frame, intensity, disparity} is not
// used; disparity in tdata[16:0], intensity in tdata[24:17], start_of_frame
// rides tuser. Output m_axis: tdata holds point_x, point_y, point_z,
// pixel_intensity from the lowest bit up; tuser holds point_valid, over_limit.
// Configuration: write i_cfg_we with register index and data; write only
// while idle.
// A front stage tracks column, row and point count and pushes each pixel
// into a two-entry queue; the back end computes Z, X, Y with one shared
// radix-2 divider (three divisions per pixel). The back end takes one
// pixel at a time from the queue and starts the next only once the last
// is out; a zero denominator goes to the output without the divisions.
// Reset clears counters, queue and output valid; registers take their
// reset values. When the receiver stalls, the result holds, the back end
// waits and the queue fills, then s_axis_tready drops.
module disparity_to_point_reprojection_top #(
    parameter int unsigned MAX_WIDTH  = dpr_pkg::MaxWidthDef,
    parameter int unsigned MAX_POINTS = dpr_pkg::MaxPointsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // disparity[16:0], intensity[24:17], zero pad
    input  logic         s_axis_tuser,  // start_of_frame
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // point_x, point_y, point_z, pixel_intensity
    output logic [1:0]   m_axis_tuser,  // point_valid, over_limit
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import dpr_pkg::*;

    logic [31:0] r_fx, r_fy, r_cx, r_cy, r_ds, r_do, r_bl;
    logic [12:0] r_iw;
    logic push, full, pop, avail, pvalid, over;
    t_job job_in, job_out;
    logic [31:0] px, py, pz;
    logic [7:0]  inten;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= 32'd65536; r_fy <= 32'd65536; r_cx <= '0; r_cy <= '0;
            r_ds <= 32'd65536; r_do <= '0; r_bl <= 32'd65536; r_iw <= 13'd640;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'({5'd0, i_cfg_idx}))
                REG_FOCAL_X:    r_fx <= i_cfg_data;
                REG_FOCAL_Y:    r_fy <= i_cfg_data;
                REG_CENTER_X:   r_cx <= i_cfg_data;
                REG_CENTER_Y:   r_cy <= i_cfg_data;
                REG_DISP_SCALE: r_ds <= i_cfg_data;
                REG_DISP_OFFS:  r_do <= i_cfg_data;
                REG_BASELINE:   r_bl <= i_cfg_data;
                REG_IMG_WIDTH:  r_iw <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    dpr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_disp(s_axis_tdata[16:0]), .i_inten(s_axis_tdata[24:17]),
        .i_sof(s_axis_tuser), .i_image_width(r_iw), .o_push(push), .o_job(job_in),
        .i_full(full)
    );

    dpr_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(job_in), .o_full(full),
        .i_pop(pop), .o_avail(avail), .o_job(job_out)
    );

    dpr_back u_back (
        .i_clk, .i_rst_n, .i_avail(avail), .i_job(job_out), .o_pop(pop),
        .i_focal_x(r_fx), .i_focal_y(r_fy), .i_center_x(r_cx), .i_center_y(r_cy),
        .i_disp_scale(r_ds), .i_disp_offset(r_do), .i_baseline(r_bl),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_px(px), .o_py(py),
        .o_pz(pz), .o_inten(inten), .o_pvalid(pvalid), .o_over(over)
    );

    assign m_axis_tdata = {inten, pz, py, px};
    assign m_axis_tuser = {over, pvalid};
endmodule

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dpr_pkg::*;

    localparam int unsigned MAX_PTS = 1048576;
    localparam int unsigned MAX_W   = 4096;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [7:0]  inten;
        logic        valid;
        logic        over;
    } t_point;

    typedef struct {
        logic [16:0] disp;
        logic [7:0]  inten;
        logic        sof;
        logic        known;   // expected point typed in below
        t_point      pt;
    } t_pixel_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;

    disparity_to_point_reprojection_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // camera setup mirrored for prediction
    logic [31:0] cam_reg [0:7];
    logic [11:0] col_cnt, row_cnt;
    logic [20:0] pt_cnt;

    t_point expected_points[$];
    int     err_cnt;
    bit     quiet_out;     // receiver never stalls while set
    bit     quiet_in;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("tb_top: errors");
        $finish;
    end

    function automatic logic [31:0] saturate(input logic [63:0] mag, input bit neg);
        if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [31:0] offset_axis(input logic [11:0] pos,
            input logic [31:0] center, input logic [31:0] z, input logic [31:0] focal);
        longint diff;
        longint zs;
        logic [63:0] prod;
        diff = longint'({pos, 16'h0}) - longint'({32'h0, center});
        zs = longint'($signed(z));
        if (focal == 0) return 32'h0;
        prod = 64'(diff < 0 ? -diff : diff) * 64'(zs < 0 ? -zs : zs);
        return saturate(prod / {32'h0, focal}, (diff < 0) != (zs < 0));
    endfunction

    // advance the pixel position and return the point it maps to
    function automatic t_point reproject(input logic [16:0] disp,
            input logic [7:0] inten, input logic sof);
        t_point r;
        longint den;
        logic [63:0] num, dmag;
        int unsigned w;
        if (sof) begin
            col_cnt = '0; row_cnt = '0; pt_cnt = '0;
        end
        r = '0;
        r.inten = inten;
        r.over = (pt_cnt >= MAX_PTS);
        den = longint'($signed(disp)) * longint'($signed(cam_reg[REG_DISP_SCALE]))
            + longint'($signed(cam_reg[REG_DISP_OFFS]));
        if (den != 0) begin
            num = 64'(cam_reg[REG_BASELINE]) * 64'(cam_reg[REG_FOCAL_X]);
            dmag = den < 0 ? 64'(-den) : 64'(den);
            r.pz = saturate(num / dmag, den < 0);
            r.px = offset_axis(col_cnt, cam_reg[REG_CENTER_X], r.pz, cam_reg[REG_FOCAL_X]);
            r.py = offset_axis(row_cnt, cam_reg[REG_CENTER_Y], r.pz, cam_reg[REG_FOCAL_Y]);
            r.valid = 1'b1;
        end
        if (pt_cnt < MAX_PTS) pt_cnt++;
        w = cam_reg[REG_IMG_WIDTH];
        if (w == 0 || w > MAX_W) w = MAX_W;
        if (32'(col_cnt) + 1 >= w) begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
        end else begin
            col_cnt++;
        end
        return r;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[2:0];
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cam_reg[idx] = (idx == REG_IMG_WIDTH) ? (val & 32'h1FFF) : val;
        @(posedge i_clk);
    endtask

    // hold until every point is back, then let the divider drain
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [16:0] disp, input logic [7:0] inten,
            input logic sof, input bit known, input t_point pt);
        t_point p;
        while (!quiet_in && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'h0, inten, disp};
        s_axis_tuser  <= sof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = reproject(disp, inten, sof);
        if (known && p !== pt)
            $display("%0t: table row disagrees with prediction exp=%h pred=%h",
                $time, pt, p);
        expected_points.push_back(known ? pt : p);
    endtask

    // output side: random stall, compare each transfer
    always @(posedge i_clk) begin
        t_point got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                    m_axis_tdata[103:96], m_axis_tuser[0], m_axis_tuser[1]};
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected point %h", $time, got);
                    err_cnt++;
                end else begin
                    want = expected_points.pop_front();
                    if (got.px !== want.px) begin
                        $display("%0t: point_x exp=%h act=%h", $time, want.px, got.px);
                        err_cnt++;
                    end
                    if (got.py !== want.py) begin
                        $display("%0t: point_y exp=%h act=%h", $time, want.py, got.py);
                        err_cnt++;
                    end
                    if (got.pz !== want.pz) begin
                        $display("%0t: point_z exp=%h act=%h", $time, want.pz, got.pz);
                        err_cnt++;
                    end
                    if (got.inten !== want.inten) begin
                        $display("%0t: intensity exp=%h act=%h", $time, want.inten,
                            got.inten);
                        err_cnt++;
                    end
                    if (got.valid !== want.valid) begin
                        $display("%0t: point_valid exp=%b act=%b", $time, want.valid,
                            got.valid);
                        err_cnt++;
                    end
                    if (got.over !== want.over) begin
                        $display("%0t: over_limit exp=%b act=%b", $time, want.over,
                            got.over);
                        err_cnt++;
                    end
                end
            end
            m_axis_tready <= quiet_out || ($urandom_range(99) >= 35);
        end
    end

    function automatic logic [16:0] rand_disp();
        case ($urandom_range(5))
            0:       return 17'h0;
            1:       return 17'($urandom_range(255));
            2:       return 17'h10000 | 17'($urandom_range(65535));
            default: return 17'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(16)) << 16;
            default: return $urandom;
        endcase
    endfunction

    t_pixel_row pixel_table[$];

    initial begin
        t_point pt;
        err_cnt = 0;
        quiet_out = 0;
        quiet_in = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cam_reg[REG_FOCAL_X] = 32'h1_0000;
        cam_reg[REG_FOCAL_Y] = 32'h1_0000;
        cam_reg[REG_CENTER_X] = 0;
        cam_reg[REG_CENTER_Y] = 0;
        cam_reg[REG_DISP_SCALE] = 32'h1_0000;
        cam_reg[REG_DISP_OFFS] = 0;
        cam_reg[REG_BASELINE] = 32'h1_0000;
        cam_reg[REG_IMG_WIDTH] = 640;
        col_cnt = '0; row_cnt = '0; pt_cnt = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setup: Z = 1/disp, zero disparity gives an invalid zero point
        pixel_table = '{
            '{17'd1, 8'h00, 1'b1, 1'b1, '{32'h0, 32'h0, 32'h1_0000, 8'h00, 1'b1, 1'b0}},
            '{17'd0, 8'hFF, 1'b0, 1'b1, '{32'h0, 32'h0, 32'h0, 8'hFF, 1'b0, 1'b0}},
            '{17'd2, 8'h5A, 1'b0, 1'b1, '{32'h1_0000, 32'h0, 32'h8000, 8'h5A, 1'b1, 1'b0}},
            '{17'h1FFFF, 8'hA5, 1'b0, 1'b0, '0},
            '{17'h10000, 8'h01, 1'b0, 1'b0, '0},
            '{17'h0FFFF, 8'h80, 1'b0, 1'b0, '0},
            '{17'd1, 8'h7F, 1'b1, 1'b1, '{32'h0, 32'h0, 32'h1_0000, 8'h7F, 1'b1, 1'b0}}
        };
        foreach (pixel_table[i])
            send_pixel(pixel_table[i].disp, pixel_table[i].inten, pixel_table[i].sof,
                pixel_table[i].known, pixel_table[i].pt);
        drain();

        // extreme setup: saturation, narrow rows, width out of range
        write_reg(REG_FOCAL_X, 32'hFFFF_FFFF);
        write_reg(REG_FOCAL_Y, 32'h0);
        write_reg(REG_CENTER_X, 32'hFFFF_FFFF);
        write_reg(REG_CENTER_Y, 32'h0);
        write_reg(REG_DISP_SCALE, 32'h8000_0000);
        write_reg(REG_DISP_OFFS, 32'h7FFF_FFFF);
        write_reg(REG_BASELINE, 32'hFFFF_FFFF);
        write_reg(REG_IMG_WIDTH, 32'd1);
        for (int i = 0; i < 8; i++)
            send_pixel(i < 4 ? 17'h1FFFF - 17'(i) : 17'(i - 4), 8'(i * 37), i == 0, 0, pt);
        drain();
        write_reg(REG_IMG_WIDTH, 32'd0);
        write_reg(REG_FOCAL_X, 32'h0);
        write_reg(REG_DISP_OFFS, 32'h8000_0000);
        write_reg(REG_DISP_SCALE, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) send_pixel(17'(i), 8'hC3, 1'b0, 0, pt);
        drain();
        write_reg(REG_IMG_WIDTH, 32'h1FFF);
        write_reg(REG_BASELINE, 32'h0);
        for (int i = 0; i < 3; i++) send_pixel(rand_disp(), 8'h3C, 1'b0, 0, pt);
        drain();

        // random phases with fresh setups
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_FOCAL_X, rand_word());
            write_reg(REG_FOCAL_Y, rand_word());
            write_reg(REG_CENTER_X, rand_word());
            write_reg(REG_CENTER_Y, rand_word());
            write_reg(REG_DISP_SCALE, rand_word());
            write_reg(REG_DISP_OFFS, rand_word());
            write_reg(REG_BASELINE, rand_word());
            write_reg(REG_IMG_WIDTH, $urandom_range(3) == 0 ? $urandom_range(8191)
                : $urandom_range(1, 12));
            quiet_out = (ph == 3);
            quiet_in = (ph == 3);
            for (int i = 0; i < 72; i++)
                send_pixel(rand_disp(), 8'($urandom), $urandom_range(19) == 0, 0, pt);
            drain();
        end
        quiet_out = 0;
        quiet_in = 0;

        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0 && expected_points.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
